### hw/rtl/request_retry_tracker_assert.svh
// assertion macros for the retry tracker checker
`ifndef REQUEST_RETRY_TRACKER_ASSERT_SVH
`define REQUEST_RETRY_TRACKER_ASSERT_SVH

// same-cycle implication under an active-low reset
`define RRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under an active-low reset
`define RRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rrt_pkg.sv
package rrt_pkg;

  typedef enum logic [2:0] {
    ACT_ISSUE    = 3'd0,
    ACT_RESPONSE = 3'd1,
    ACT_CANCEL   = 3'd2,
    ACT_TICK     = 3'd3,
    ACT_CONN_DONE = 3'd4,
    ACT_LINK_LOST = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    KIND_ISSUED    = 3'd0,
    KIND_RETRANS   = 3'd1,
    KIND_DONE_OK   = 3'd2,
    KIND_FAILED    = 3'd3,
    KIND_CONNECT   = 3'd4,
    KIND_HBEAT_REJ = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    LINK_DOWN       = 2'd0,
    LINK_CONNECTING = 2'd1,
    LINK_UP         = 2'd2
  } link_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HBEAT,
    ST_FLUSH
  } state_e;

  localparam logic [1:0] CFG_RECONNECT = 2'd0;
  localparam logic [1:0] CFG_HB_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_HB_COMMAND = 2'd2;

  localparam logic [15:0] RECONNECT_RESET = 16'd5;
  localparam logic [15:0] HB_INTERVAL_RESET = 16'd30;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] command;
    logic [31:0] sequence_nr;
    logic [7:0]  tries_done;
    logic [7:0]  tries_limit;
    logic [15:0] interval;
    logic [31:0] last_sent;
  } entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        sent;
    logic [31:0] send_id;
    logic [31:0] cmd;
    logic [31:0] seq;
  } result_t;

endpackage

### hw/rtl/request_retry_tracker.sv
// Outstanding-request table of a reliable request/response link. A transaction is
// accepted when start is high and busy is low; every result is shown for exactly
// one cycle with out_valid_o high and cannot be stalled, so the receiver must take it
// then, and last_o marks the final result of a transaction. Issue, connect done, link
// lost and unused codes finish at once (issue shows its result in the next cycle).
// Response, cancel and tick sweep the stored entries through the table memory, one
// read a cycle, compacting kept entries downward; busy stays high through the
// sweep, a tick then passes through a heartbeat state, and every sweep ends in a
// flush state. Results are held in a pending register so last_o can be known.
module request_retry_tracker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [31:0] cmd_i,
  input  logic [31:0] seq_i,
  input  logic [31:0] send_id_i,
  input  logic [7:0]  max_tries_i,
  input  logic [15:0] retry_interval_i,
  input  logic        connect_ok_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  output logic [2:0]  kind_o,
  output logic        sent_o,
  output logic [31:0] out_send_id_o,
  output logic [31:0] out_cmd_o,
  output logic [31:0] out_seq_o,
  output logic        last_o
);
  import rrt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // table memory, one synchronous read port and one write port
  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] reconn_int_q;
  logic [15:0] hb_int_q;
  logic [31:0] hb_cmd_q;

  // scalar link state
  logic [31:0] time_q, time_d;
  logic [31:0] next_seq_q, next_seq_d;
  logic [31:0] next_id_q, next_id_d;
  link_e       link_q, link_d;
  logic [31:0] last_conn_q, last_conn_d;
  logic [31:0] last_hb_q, last_hb_d;

  // sweep control: entry count, read pointer, write pointer, read-data valid
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] wptr_q, wptr_d;
  logic          pv_q, pv_d;
  logic          found_q, found_d;

  // captured transaction fields
  logic [2:0]  act_q, act_d;
  logic [31:0] cmd_q, cmd_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] sid_q, sid_d;

  // pending result, held so the last flag can be set on the final one
  logic    pend_v_q, pend_v_d;
  result_t pend_q, pend_d;

  logic    new_v;
  result_t new_r;

  logic accept;
  logic sweep_done;
  logic [31:0] tick_time;
  logic [31:0] elapsed;
  entry_t upd;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy;
  assign sweep_done  = (rptr_q == count_q) && !pv_q;
  assign tick_time   = time_q + 32'd1;
  assign elapsed     = time_q - rd_q.last_sent;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_ISSUE: state_d = ST_FLUSH;
            ACT_RESPONSE, ACT_CANCEL, ACT_TICK: state_d = ST_SWEEP;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          state_d = (act_q == ACT_TICK) ? ST_HBEAT : ST_FLUSH;
        end
      end
      ST_HBEAT: state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and memory access
  always_comb begin
    time_d      = time_q;
    next_seq_d  = next_seq_q;
    next_id_d   = next_id_q;
    link_d      = link_q;
    last_conn_d = last_conn_q;
    last_hb_d   = last_hb_q;
    count_d     = count_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    pv_d        = 1'b0;
    found_d     = found_q;
    act_d       = act_q;
    cmd_d       = cmd_q;
    seq_d       = seq_q;
    sid_d       = sid_q;
    new_v       = 1'b0;
    new_r       = '0;
    rd_en       = 1'b0;
    rd_addr     = rptr_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = wptr_q[AW-1:0];
    wr_data     = rd_q;
    upd         = rd_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d   = action_i;
          cmd_d   = cmd_i;
          seq_d   = seq_i;
          sid_d   = send_id_i;
          rptr_d  = '0;
          wptr_d  = '0;
          found_d = 1'b0;
          case (action_i)
            ACT_ISSUE: begin
              new_v = 1'b1;
              if (count_q == CW'(TABLE_DEPTH)) begin
                // table full: reject without consuming an id
                new_r.kind = KIND_HBEAT_REJ;
                new_r.cmd  = cmd_i;
              end else begin
                next_id_d  = next_id_q + 32'd1;
                next_seq_d = next_seq_q + 32'd1;
                wr_en      = 1'b1;
                wr_addr    = count_q[AW-1:0];
                wr_data.id          = next_id_d;
                wr_data.command     = cmd_i;
                wr_data.sequence_nr = next_seq_d;
                wr_data.tries_done  = 8'd1;
                wr_data.tries_limit = max_tries_i;
                wr_data.interval    = retry_interval_i;
                wr_data.last_sent   = time_q;
                count_d       = count_q + CW'(1);
                new_r.kind    = KIND_ISSUED;
                new_r.sent    = (link_q == LINK_UP);
                new_r.send_id = next_id_d;
                new_r.cmd     = cmd_i;
                new_r.seq     = next_seq_d;
              end
            end
            ACT_TICK: begin
              time_d = tick_time;
              // reconnect attempt while down
              if (link_q == LINK_DOWN &&
                  (tick_time - last_conn_q) >= {16'd0, reconn_int_q}) begin
                link_d      = LINK_CONNECTING;
                last_conn_d = tick_time;
                new_v       = 1'b1;
                new_r.kind  = KIND_CONNECT;
              end
            end
            ACT_CONN_DONE: begin
              if (link_q == LINK_CONNECTING) begin
                link_d = connect_ok_i ? LINK_UP : LINK_DOWN;
              end
            end
            ACT_LINK_LOST: link_d = LINK_DOWN;
            default: ;
          endcase
        end
      end

      ST_SWEEP: begin
        // issue the next read; writes only land at or below the read pointer
        if (rptr_q != count_q) begin
          rd_en  = 1'b1;
          rptr_d = rptr_q + CW'(1);
          pv_d   = 1'b1;
        end
        if (pv_q) begin
          wr_en = 1'b1;
          case (act_q)
            ACT_RESPONSE: begin
              if (!found_q && rd_q.command == cmd_q && rd_q.sequence_nr == seq_q) begin
                found_d       = 1'b1;
                wr_en         = 1'b0;
                new_v         = 1'b1;
                new_r.kind    = KIND_DONE_OK;
                new_r.send_id = rd_q.id;
                new_r.cmd     = cmd_q;
                new_r.seq     = seq_q;
              end
            end
            ACT_CANCEL: begin
              if (!found_q && rd_q.id == sid_q) begin
                found_d = 1'b1;
                wr_en   = 1'b0;
              end
            end
            default: begin
              // tick: age the entry
              if (elapsed >= {16'd0, rd_q.interval}) begin
                new_v         = 1'b1;
                new_r.send_id = rd_q.id;
                new_r.cmd     = rd_q.command;
                new_r.seq     = rd_q.sequence_nr;
                if (rd_q.tries_done >= rd_q.tries_limit) begin
                  new_r.kind = KIND_FAILED;
                  wr_en      = 1'b0;
                end else begin
                  new_r.kind     = KIND_RETRANS;
                  new_r.sent     = (link_q == LINK_UP);
                  upd.tries_done = rd_q.tries_done + 8'd1;
                  upd.last_sent  = time_q;
                end
              end
            end
          endcase
          wr_data = upd;
          if (wr_en) begin
            wptr_d = wptr_q + CW'(1);
          end
        end
        if (sweep_done) begin
          count_d = wptr_q;
        end
      end

      ST_HBEAT: begin
        if (link_q == LINK_UP && (time_q - last_hb_q) >= {16'd0, hb_int_q}) begin
          next_seq_d = next_seq_q + 32'd1;
          last_hb_d  = time_q;
          new_v      = 1'b1;
          new_r.kind = KIND_HBEAT_REJ;
          new_r.sent = 1'b1;
          new_r.cmd  = hb_cmd_q;
          new_r.seq  = next_seq_d;
        end
      end

      default: ;
    endcase
  end

  // pending result and output strobe
  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    if (new_v) begin
      pend_v_d = 1'b1;
      pend_d   = new_r;
    end else if (state_q == ST_FLUSH) begin
      pend_v_d = 1'b0;
    end
  end

  assign out_valid_o   = pend_v_q && (new_v || state_q == ST_FLUSH);
  assign last_o        = (state_q == ST_FLUSH);
  assign kind_o        = pend_q.kind;
  assign sent_o        = pend_q.sent;
  assign out_send_id_o = pend_q.send_id;
  assign out_cmd_o     = pend_q.cmd;
  assign out_seq_o     = pend_q.seq;

  // table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    cmd_q  <= cmd_d;
    seq_q  <= seq_d;
    sid_q  <= sid_d;
    pend_q <= pend_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      reconn_int_q <= RECONNECT_RESET;
      hb_int_q     <= HB_INTERVAL_RESET;
      hb_cmd_q     <= '0;
      time_q       <= '0;
      next_seq_q   <= '0;
      next_id_q    <= '0;
      link_q       <= LINK_DOWN;
      last_conn_q  <= '0;
      last_hb_q    <= '0;
      count_q      <= '0;
      rptr_q       <= '0;
      wptr_q       <= '0;
      pv_q         <= 1'b0;
      found_q      <= 1'b0;
      pend_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      next_seq_q  <= next_seq_d;
      next_id_q   <= next_id_d;
      link_q      <= link_d;
      last_conn_q <= last_conn_d;
      last_hb_q   <= last_hb_d;
      count_q     <= count_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      pend_v_q    <= pend_v_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_RECONNECT:   reconn_int_q <= cfg_data_i[15:0];
          CFG_HB_INTERVAL: hb_int_q     <= cfg_data_i[15:0];
          CFG_HB_COMMAND:  hb_cmd_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

### hw/rtl/rrt_checker.sv
`include "request_retry_tracker_assert.svh"

module rrt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [2:0] action_i,
  input logic       out_valid_o,
  input logic [2:0] kind_o,
  input logic       last_o
);
  import rrt_pkg::*;

  logic accept;
  assign accept = start && !busy;

  `RRT_ASSERT_NXT(a_issue_one_result, clk_i, rst_ni, accept && action_i == ACT_ISSUE, out_valid_o && last_o, "issue did not give a single result")
  `RRT_ASSERT_IMP(a_result_while_busy, clk_i, rst_ni, out_valid_o, busy, "result while idle")
  `RRT_ASSERT_NXT(a_idle_after_last, clk_i, rst_ni, out_valid_o && last_o, !busy, "still busy after final result")
  `RRT_ASSERT_IMP(a_issued_is_last, clk_i, rst_ni, out_valid_o && kind_o == KIND_ISSUED, last_o, "issued result not final")
  `RRT_ASSERT_NXT(a_link_ops_quick, clk_i, rst_ni, accept && (action_i == ACT_CONN_DONE || action_i == ACT_LINK_LOST), !busy, "link transaction kept block busy")

endmodule

bind request_retry_tracker rrt_checker u_rrt_checker (.*);
